// File: src/infix_to_postfix_converter_defines.svh
// Assertion macros for the infix to postfix converter.
`ifndef INFIX_TO_POSTFIX_CONVERTER_DEFINES_SVH
`define INFIX_TO_POSTFIX_CONVERTER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define I2P_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define I2P_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: src/i2p_pkg.sv
// Shared types, character codes and helpers for the infix to postfix converter.
`timescale 1ns / 1ps

package i2p_pkg;

	// Character codes
	localparam logic [7:0] CH_OPEN  = 8'h28;
	localparam logic [7:0] CH_CLOSE = 8'h29;
	localparam logic [7:0] CH_MUL   = 8'h2A;
	localparam logic [7:0] CH_ADD   = 8'h2B;
	localparam logic [7:0] CH_SUB   = 8'h2D;
	localparam logic [7:0] CH_DIV   = 8'h2F;

	// Input word opcodes
	localparam logic OP_CHAR = 1'b0;
	localparam logic OP_END  = 1'b1;

	// Operator ranks
	localparam logic [1:0] RANK_NONE = 2'd0;
	localparam logic [1:0] RANK_ADD  = 2'd1;
	localparam logic [1:0] RANK_MUL  = 2'd2;

	// Command queue between front and back
	localparam int unsigned Q_DEPTH = 4;
	localparam int unsigned Q_AW    = 2;
	localparam int unsigned Q_CW    = 3;

	typedef struct packed {
		logic       op;
		logic [7:0] ch;
	} sym_t;

	typedef struct packed {
		logic [7:0] out_char;
		logic       last;
		logic       overflowed;
	} post_t;

	typedef enum logic [2:0] {
		K_EMIT,
		K_OPEN,
		K_OPER,
		K_CLOSE,
		K_FLUSH
	} kind_t;

	typedef struct packed {
		kind_t      kind;
		logic [1:0] rank;
		logic [7:0] ch;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
		logic ovf;
	} stk_stat_t;

	// Rank of a byte: 1 for + and -, 2 for * and /, 0 otherwise
	function automatic logic [1:0] rank_of(input logic [7:0] c);
		logic [1:0] r;
		r = RANK_NONE;
		if (c == CH_ADD || c == CH_SUB)
			r = RANK_ADD;
		else if (c == CH_MUL || c == CH_DIV)
			r = RANK_MUL;
		return r;
	endfunction

endpackage

// File: src/i2p_front.sv
// Front end: accepts input words, classifies them and feeds the command queue.
`timescale 1ns / 1ps

module i2p_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          sym_valid,
	output logic          sym_stall,
	input  i2p_pkg::sym_t sym,
	input  logic          q_full,
	output logic          q_push,
	output i2p_pkg::cmd_t q_cmd
);
	import i2p_pkg::*;

	logic valid_s1;
	cmd_t cmd_s1;
	cmd_t cls;

	// Classify the incoming byte
	always_comb begin
		cls.ch   = sym.ch;
		cls.rank = rank_of(sym.ch);
		if (sym.op == OP_END)
			cls.kind = K_FLUSH;
		else if (sym.ch == CH_OPEN)
			cls.kind = K_OPEN;
		else if (cls.rank != RANK_NONE)
			cls.kind = K_OPER;
		else if (sym.ch == CH_CLOSE)
			cls.kind = K_CLOSE;
		else
			cls.kind = K_EMIT;
	end

	// Hold the stage while the queue is full
	assign sym_stall = valid_s1 && q_full;
	assign q_push    = valid_s1 && !q_full;
	assign q_cmd     = cmd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!sym_stall) begin
			valid_s1 <= sym_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!sym_stall && sym_valid) begin
			cmd_s1 <= cls;
		end
	end

endmodule

// File: src/i2p_queue.sv
// Short command queue that decouples the front end from the stack engine.
`timescale 1ns / 1ps

module i2p_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  i2p_pkg::cmd_t push_cmd,
	output logic          full,
	input  logic          pop,
	output logic          head_valid,
	output i2p_pkg::cmd_t head_cmd
);
	import i2p_pkg::*;

	cmd_t            q_mem [Q_DEPTH];
	logic [Q_AW-1:0] wptr_q;
	logic [Q_AW-1:0] rptr_q;
	logic [Q_CW-1:0] cnt_q;

	assign full       = cnt_q == Q_CW'(Q_DEPTH);
	assign head_valid = cnt_q != '0;
	assign head_cmd   = q_mem[rptr_q];

	// Storage
	always_ff @(posedge clk) begin
		if (push) begin
			q_mem[wptr_q] <= push_cmd;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push)
				wptr_q <= wptr_q + Q_AW'(1);
			if (pop)
				rptr_q <= rptr_q + Q_AW'(1);
			if (push && !pop)
				cnt_q <= cnt_q + Q_CW'(1);
			else if (pop && !push)
				cnt_q <= cnt_q - Q_CW'(1);
		end
	end

endmodule

// File: src/i2p_back.sv
// Stack engine: runs queued commands on the stack, a step a cycle unless stalled.
`timescale 1ns / 1ps

module i2p_back #(
	parameter int STACK_DEPTH = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               head_valid,
	input  i2p_pkg::cmd_t      head_cmd,
	output logic               pop,
	output logic               post_valid,
	input  logic               post_stall,
	output i2p_pkg::post_t     post,
	output i2p_pkg::stk_stat_t stat
);
	import i2p_pkg::*;

	localparam int CW = $clog2(STACK_DEPTH + 1);
	localparam int AW = $clog2(STACK_DEPTH);

	// Top of stack lives in top_q; entries below it live in the memory.
	logic [7:0]    stk_mem [STACK_DEPTH];
	logic [CW-1:0] count_q;
	logic [7:0]    top_q;
	logic [7:0]    rd_q;
	logic          ovf_q;
	logic          cur_valid_q;
	cmd_t          cur_q;
	logic          out_valid_q;
	post_t         out_q;

	logic          step, take;
	logic          nonempty, two, one, full;
	logic          top_open, rd_open;
	logic          do_push, do_pop, do_emit, done;
	logic [7:0]    emit_char;
	logic          emit_last;
	logic          push_en, pop_en, emit_en, wr_en;
	logic [CW-1:0] count_d, count_m1, raddr_full;
	logic [AW-1:0] waddr, raddr;

	assign step     = cur_valid_q && (!out_valid_q || !post_stall);
	assign nonempty = count_q != '0;
	assign two      = count_q >= CW'(2);
	assign one      = count_q == CW'(1);
	assign full     = count_q == CW'(STACK_DEPTH);
	assign top_open = top_q == CH_OPEN;
	assign rd_open  = rd_q == CH_OPEN;

	// One step of the current command; last is decided by looking one entry down
	always_comb begin
		do_push   = 1'b0;
		do_pop    = 1'b0;
		do_emit   = 1'b0;
		done      = 1'b0;
		emit_char = top_q;
		emit_last = 1'b0;
		case (cur_q.kind)
			K_EMIT: begin
				do_emit   = 1'b1;
				emit_char = cur_q.ch;
				emit_last = 1'b1;
				done      = 1'b1;
			end
			K_OPEN: begin
				do_push = 1'b1;
				done    = 1'b1;
			end
			K_OPER: begin
				if (nonempty && !top_open && rank_of(top_q) >= cur_q.rank) begin
					do_pop    = 1'b1;
					do_emit   = 1'b1;
					emit_last = !(two && !rd_open && rank_of(rd_q) >= cur_q.rank);
				end else begin
					do_push = 1'b1;
					done    = 1'b1;
				end
			end
			K_CLOSE: begin
				if (!nonempty) begin
					done = 1'b1;
				end else if (top_open) begin
					do_pop = 1'b1;
					done   = 1'b1;
				end else begin
					do_pop    = 1'b1;
					do_emit   = 1'b1;
					emit_last = !two || rd_open;
				end
			end
			K_FLUSH: begin
				if (!nonempty) begin
					done = 1'b1;
				end else begin
					do_pop    = 1'b1;
					do_emit   = 1'b1;
					emit_last = one;
				end
			end
			default: begin
				done = 1'b1;
			end
		endcase
	end

	assign push_en = step && do_push;
	assign pop_en  = step && do_pop;
	assign emit_en = step && do_emit;
	assign wr_en   = push_en && !full && nonempty;

	// Next count and memory addresses
	always_comb begin
		count_d = count_q;
		if (push_en && !full)
			count_d = count_q + CW'(1);
		else if (pop_en)
			count_d = count_q - CW'(1);
	end

	assign count_m1   = count_q - CW'(1);
	assign raddr_full = count_d - CW'(2);
	assign waddr      = count_m1[AW-1:0];
	assign raddr      = raddr_full[AW-1:0];

	// Fetch the next command when idle or when this one finishes
	assign take = !cur_valid_q || (step && done);
	assign pop  = take && head_valid;

	// Stack memory; the read port tracks the entry under the next top
	always_ff @(posedge clk) begin
		if (wr_en) begin
			stk_mem[waddr] <= top_q;
		end
		rd_q <= wr_en ? top_q : stk_mem[raddr];
	end

	// Stack control and current command
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			ovf_q       <= 1'b0;
			cur_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			count_q <= count_d;
			if (push_en && full)
				ovf_q <= 1'b1;
			if (take)
				cur_valid_q <= head_valid;
			if (emit_en)
				out_valid_q <= 1'b1;
			else if (!post_stall)
				out_valid_q <= 1'b0;
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (push_en && !full)
			top_q <= cur_q.ch;
		else if (pop_en)
			top_q <= rd_q;
		if (pop)
			cur_q <= head_cmd;
		if (emit_en) begin
			out_q.out_char   <= emit_char;
			out_q.last       <= emit_last;
			out_q.overflowed <= ovf_q;
		end
	end

	assign post_valid = out_valid_q;
	assign post       = out_q;
	assign stat.full  = full;
	assign stat.empty = !nonempty;
	assign stat.ovf   = ovf_q;

endmodule

// File: src/infix_to_postfix_converter.sv
// Infix to postfix converter: top level joining front end, queue and stack engine.
// Usage:
//   Input channel (sym_valid / sym_stall / sym): one word per infix byte, op = 0,
//   or an end word, op = 1, that empties the operator stack. Output channel
//   (post_valid / post_stall / post): one word per postfix byte; last marks the
//   final word caused by an input word, overflowed is the sticky stack-overflow flag.
//   An operand byte passes the input stage, the queue and the current-command
//   register before it is registered onto post. Stack engine steps: operands and
//   '(' take one each; an operator, one per popped entry plus one for its push;
//   ')' and the end word, one per emitted entry plus one to finish. The engine
//   pops one entry a cycle, unless the output stalls, from a single-write,
//   single-read memory. A four-word command queue lets input flow while pops run.
//   Reset (arst_n low) empties the stack and queue and clears the overflow flag.
//   A stalled output word holds; the engine waits, the queue fills, and
//   sym_stall rises once the queue and the input stage are full.
`timescale 1ns / 1ps
`include "infix_to_postfix_converter_defines.svh"

module infix_to_postfix_converter #(
	parameter int STACK_DEPTH = 32
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           sym_valid,
	output logic           sym_stall,
	input  i2p_pkg::sym_t  sym,
	output logic           post_valid,
	input  logic           post_stall,
	output i2p_pkg::post_t post
);
	import i2p_pkg::*;

	logic      q_full;
	logic      q_push;
	cmd_t      q_cmd;
	logic      head_valid;
	cmd_t      head_cmd;
	logic      q_pop;
	stk_stat_t stk_st;

	i2p_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.sym_valid (sym_valid),
		.sym_stall (sym_stall),
		.sym       (sym),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_cmd     (q_cmd)
	);

	i2p_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_cmd   (q_cmd),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (head_valid),
		.head_cmd   (head_cmd)
	);

	i2p_back #(
		.STACK_DEPTH (STACK_DEPTH)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_cmd   (head_cmd),
		.pop        (q_pop),
		.post_valid (post_valid),
		.post_stall (post_stall),
		.post       (post),
		.stat       (stk_st)
	);

	// Checks
	`I2P_ASSERT_NOW(a_stack_state, clk, arst_n, 1'b1, !(stk_st.full && stk_st.empty), "stack full and empty")
	`I2P_ASSERT_NEXT(a_ovf_sticky, clk, arst_n, stk_st.ovf, stk_st.ovf, "overflow flag cleared")
	`I2P_ASSERT_NOW(a_ovf_source, clk, arst_n, post_valid, !post.overflowed || stk_st.ovf, "overflowed without flag")
	`I2P_ASSERT_NOW(a_queue_push, clk, arst_n, q_push, !q_full, "push into full queue")

endmodule
